FILE: rtl/core/aespr_pkg.sv
// Package for the partial AES round block: the S-box table and a byte helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aespr_pkg;

	localparam int NumBytes = 16;

	typedef logic [7:0] byte_t;
	typedef byte_t [NumBytes-1:0] block_t;

	// Standard AES substitution table, indexed by input byte.
	localparam byte_t SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// Byte i of a 128-bit block, byte 0 in the top bits.
	function automatic byte_t get_byte(input logic [127:0] w, input int unsigned i);
		get_byte = w[127 - 8*i -: 8];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/aespr_datapath.sv
// Combinational round datapath: key XOR, S-box on all bytes, row rotation.
// Depends on aespr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aespr_datapath import aespr_pkg::*; (
	input  wire logic [127:0] state,
	input  wire logic [127:0] key,
	output logic      [127:0] result
);

	block_t sub;

	// Sixteen parallel key additions and table lookups.
	always_comb begin
		for (int i = 0; i < NumBytes; i++) begin
			sub[i] = SBOX[get_byte(state, i) ^ get_byte(key, i)];
		end
	end

	// Row r rotates left by r byte positions.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				result[127 - 8*(r*4 + c) -: 8] = sub[r*4 + ((c + r) % 4)];
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/aespr_out_stage.sv
// Result register with valid/ready handshake; accepts while a word drains.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none
module aespr_out_stage (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire logic [127:0] d,
	input  wire logic         out_ready,
	output logic              out_valid,
	output logic [127:0]      q,
	output logic              can_load
);

	logic         valid_q;
	logic [127:0] data_q;

	// The register takes a new word when empty or when its word leaves now.
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign q         = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_q <= d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/aes_partial_round.sv
// Top level of the partial AES round: input register, datapath, result register.
// Depends on aespr_pkg, aespr_datapath and aespr_out_stage.
`timescale 1ns / 1ps
`default_nettype none
// One word is accepted per cycle when the output side keeps up. A word is
// captured in an input register at the edge that accepts it. It then passes
// through the key XOR, sixteen S-box lookups and the row rotation, and lands
// in a result register at the first edge at which that register can load.
// A stalled result register holds the input register, which then drops
// ready. The block keeps no state between words.
module aes_partial_round import aespr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] state_hi,
	input  wire logic [63:0] state_lo,
	input  wire logic [63:0] key_hi,
	input  wire logic [63:0] key_lo,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [63:0] result_hi,
	output logic      [63:0] result_lo
);

	logic         valid_s1;
	logic [127:0] state_s1;
	logic [127:0] key_s1;
	logic [127:0] round_res;
	logic [127:0] res_q;
	logic         can_load;

	// Input stage advances when it is empty or the result register can take its word.
	assign in_ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			state_s1 <= {state_hi, state_lo};
			key_s1   <= {key_hi, key_lo};
		end
	end

	aespr_datapath u_datapath (
		.state  (state_s1),
		.key    (key_s1),
		.result (round_res)
	);

	aespr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.d         (round_res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.q         (res_q),
		.can_load  (can_load)
	);

	assign result_hi = res_q[127:64];
	assign result_lo = res_q[63:0];

`ifndef SYNTHESIS
	// A held input word must not be lost while the result register is stalled.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_ready |=> valid_s1 && $stable(state_s1))
		else $error("input stage dropped a word");

	// A word in the input stage reaches the result register when it can load.
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && can_load |=> out_valid)
		else $error("word lost between stages");

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_q))
		else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire
